// ----- design/sfcb_pkg.sv -----
// Shared types, sizes and codes for the serial flow control buffers.
package sfcb_pkg;

    localparam int RX_DEPTH   = 128;
    localparam int TX_DEPTH   = 1024;
    localparam int RX_AW      = $clog2(RX_DEPTH);
    localparam int TX_AW      = $clog2(TX_DEPTH);
    localparam int RX_CW      = $clog2(RX_DEPTH + 1);
    localparam int TX_CW      = $clog2(TX_DEPTH + 1);

    localparam int LIMIT_W    = 8;
    localparam int EXT_W      = 7;
    localparam int IDLE_W     = 16;
    localparam int CFG_W      = 16;
    localparam int CFG_IDX_W  = 2;
    localparam int SUM_W      = LIMIT_W + 1;
    localparam int CAP_W      = (RX_CW > SUM_W) ? RX_CW : SUM_W;

    localparam int BYTE_W     = 8;
    localparam int RX_COUNT_W = 8;
    localparam int TX_COUNT_W = 11;
    localparam int STATUS_W   = 2;
    localparam int FUNC_W     = 2;

    localparam int S_DATA_W   = 24;
    localparam int M_DATA_W   = 48;
    localparam int S_USED_W   = 3 + 2 * BYTE_W;
    localparam int M_USED_W   = 3 + STATUS_W + 2 * BYTE_W + 1 + RX_COUNT_W + TX_COUNT_W;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_RX_LIMIT   = 2'd0,
        REG_RX_EXT     = 2'd1,
        REG_IDLE_LIMIT = 2'd2
    } cfg_idx_t;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK  = 2'd0,
        FUNC_START = 2'd1,
        FUNC_PUSH  = 2'd2,
        FUNC_POP   = 2'd3
    } func_t;

    typedef enum logic [STATUS_W-1:0] {
        EXIT_NO_ACT   = 2'd0,
        EXIT_FULL     = 2'd1,
        EXIT_OVERFLOW = 2'd2
    } exit_t;

    typedef struct packed {
        logic [CAP_W-1:0]  cap;
        logic [CAP_W-1:0]  high;
        logic [IDLE_W-1:0] idle_limit;
    } cfg_t;

    typedef struct packed {
        func_t             func;
        logic              cts;
        logic              tx_empty;
        logic              rx_avail;
        logic [BYTE_W-1:0] rx_byte;
        logic [BYTE_W-1:0] host_byte;
    } item_t;

    typedef struct packed {
        logic              tx_valid;
        logic              rts;
        logic              session_done;
        exit_t             exit_status;
        logic              rd_sel;
        logic              push_ok;
        logic [RX_COUNT_W-1:0] rx_count;
        logic [TX_COUNT_W-1:0] tx_count;
    } res_t;

    typedef struct packed {
        logic              we;
        logic [TX_AW-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [TX_AW-1:0]  raddr;
    } tx_mem_req_t;

    typedef struct packed {
        logic              we;
        logic [RX_AW-1:0]  waddr;
        logic [BYTE_W-1:0] wdata;
        logic              re;
        logic [RX_AW-1:0]  raddr;
    } rx_mem_req_t;

endpackage

// ----- design/sfcb_ram.sv -----
// Single write port, single registered read port RAM.
module sfcb_ram #(
    parameter int DEPTH  = 128,
    parameter int WIDTH  = 8,
    parameter int ADDR_W = $clog2(DEPTH)
) (
    input  logic              aclk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

// ----- design/sfcb_cfg.sv -----
// Configuration registers and derived receive capacity and high-water mark.
module sfcb_cfg (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  logic                          cfg_wr_en,
    input  logic [sfcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfcb_pkg::CFG_W-1:0]    cfg_wdata,
    output sfcb_pkg::cfg_t                cfg
);
    import sfcb_pkg::*;

    logic [LIMIT_W-1:0] rx_limit_reg;
    logic [EXT_W-1:0]   rx_ext_reg;
    logic [IDLE_W-1:0]  idle_limit_reg;
    logic [SUM_W-1:0]   sum;
    logic [CAP_W-1:0]   cap;
    logic [CAP_W-1:0]   ext_w;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            rx_limit_reg   <= LIMIT_W'(3);
            rx_ext_reg     <= EXT_W'(64);
            idle_limit_reg <= IDLE_W'(100);
        end else if (cfg_wr_en) begin
            unique case (cfg_index)
                REG_RX_LIMIT:   rx_limit_reg   <= cfg_wdata[LIMIT_W-1:0];
                REG_RX_EXT:     rx_ext_reg     <= cfg_wdata[EXT_W-1:0];
                REG_IDLE_LIMIT: idle_limit_reg <= cfg_wdata[IDLE_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        sum   = SUM_W'(rx_limit_reg) + SUM_W'(rx_ext_reg);
        ext_w = CAP_W'(rx_ext_reg);
        cap   = (CAP_W'(sum) > CAP_W'(RX_DEPTH)) ? CAP_W'(RX_DEPTH) : CAP_W'(sum);
        cfg.cap        = cap;
        cfg.high       = (cap > ext_w) ? (cap - ext_w) : '0;
        cfg.idle_limit = idle_limit_reg;
    end

endmodule

// ----- design/sfcb_ctrl.sv -----
// Session sequencer, ring pointers and fills, and the result register.
module sfcb_ctrl (
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  fire,
    input  sfcb_pkg::item_t       item,
    input  sfcb_pkg::cfg_t        cfg,
    output sfcb_pkg::tx_mem_req_t tx_req,
    output sfcb_pkg::rx_mem_req_t rx_req,
    output sfcb_pkg::res_t        res
);
    import sfcb_pkg::*;

    typedef enum logic [1:0] {
        PH_IDLE  = 2'd0,
        PH_POLL  = 2'd1,
        PH_FLUSH = 2'd2
    } phase_t;

    phase_t            phase_reg, phase_next;
    logic              rts_reg, rts_next;
    logic [IDLE_W-1:0] idle_reg, idle_next;
    logic [RX_AW-1:0]  rx_wr_reg, rx_wr_next, rx_rd_reg, rx_rd_next;
    logic [RX_CW-1:0]  rx_fill_reg, rx_fill_next;
    logic [TX_AW-1:0]  tx_wr_reg, tx_wr_next, tx_rd_reg, tx_rd_next;
    logic [TX_CW-1:0]  tx_fill_reg, tx_fill_next;
    res_t              res_reg, res_next;

    logic              rx_room;
    logic [RX_CW-1:0]  rx_fill_put;
    logic [IDLE_W-1:0] idle_inc;
    logic [IDLE_W-1:0] idle_poll;
    logic              tx_act;
    logic              tx_send;
    logic              rx_store;
    logic              tx_store;
    logic              rx_load;

    always_comb begin
        rx_room     = CAP_W'(rx_fill_reg) < cfg.cap;
        rx_fill_put = rx_room ? rx_fill_reg + 1'b1 : rx_fill_reg;
        idle_inc    = (idle_reg != '1) ? idle_reg + 1'b1 : idle_reg;
        tx_act      = item.cts && (tx_fill_reg != '0);
        idle_poll   = tx_act ? IDLE_W'(1) : idle_inc;

        phase_next   = phase_reg;
        rts_next     = rts_reg;
        idle_next    = idle_reg;
        rx_wr_next   = rx_wr_reg;
        rx_rd_next   = rx_rd_reg;
        rx_fill_next = rx_fill_reg;
        tx_wr_next   = tx_wr_reg;
        tx_rd_next   = tx_rd_reg;
        tx_fill_next = tx_fill_reg;
        tx_send      = 1'b0;
        rx_store     = 1'b0;
        tx_store     = 1'b0;
        rx_load      = 1'b0;
        res_next     = res_reg;

        if (fire) begin
            res_next.session_done = 1'b0;
            res_next.exit_status  = EXIT_NO_ACT;
            res_next.push_ok      = 1'b0;

            unique case (item.func)
                FUNC_START: begin
                    if (CAP_W'(rx_fill_reg) >= cfg.high) begin
                        res_next.session_done = 1'b1;
                        res_next.exit_status  = rx_room ? EXIT_FULL : EXIT_OVERFLOW;
                    end else begin
                        rts_next   = 1'b1;
                        phase_next = PH_POLL;
                        idle_next  = '0;
                    end
                end
                FUNC_PUSH: begin
                    if (tx_fill_reg < TX_CW'(TX_DEPTH)) begin
                        tx_store          = 1'b1;
                        res_next.push_ok  = 1'b1;
                    end
                end
                FUNC_POP: begin
                    rx_load = rx_fill_reg != '0;
                end
                FUNC_TICK: begin
                    unique case (phase_reg)
                        PH_POLL: begin
                            tx_send = tx_act && item.tx_empty;
                            if (tx_act) begin
                                idle_next = '0;
                            end
                            if (item.rx_avail) begin
                                idle_next = '0;
                                rx_store  = rx_room;
                                if (CAP_W'(rx_fill_put) >= cfg.high) begin
                                    rts_next   = 1'b0;
                                    phase_next = PH_FLUSH;
                                end
                            end else begin
                                idle_next = idle_poll;
                                if (idle_poll >= cfg.idle_limit) begin
                                    res_next.session_done = 1'b1;
                                    res_next.exit_status  = EXIT_NO_ACT;
                                    phase_next            = PH_IDLE;
                                end
                            end
                        end
                        PH_FLUSH: begin
                            if (item.rx_avail) begin
                                idle_next = '0;
                                rx_store  = rx_room;
                                if (CAP_W'(rx_fill_put) >= cfg.cap) begin
                                    res_next.session_done = 1'b1;
                                    res_next.exit_status  = EXIT_OVERFLOW;
                                    phase_next            = PH_IDLE;
                                end
                            end else begin
                                idle_next = idle_inc;
                                if (idle_inc >= cfg.idle_limit) begin
                                    res_next.session_done = 1'b1;
                                    res_next.exit_status  = EXIT_FULL;
                                    phase_next            = PH_IDLE;
                                end
                            end
                        end
                        default: ;
                    endcase
                end
                default: ;
            endcase

            if (tx_store) begin
                tx_wr_next = (tx_wr_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_wr_reg + 1'b1;
            end
            if (tx_send) begin
                tx_rd_next = (tx_rd_reg == TX_AW'(TX_DEPTH - 1)) ? '0 : tx_rd_reg + 1'b1;
            end
            unique case ({tx_store, tx_send})
                2'b10:   tx_fill_next = tx_fill_reg + 1'b1;
                2'b01:   tx_fill_next = tx_fill_reg - 1'b1;
                default: tx_fill_next = tx_fill_reg;
            endcase

            if (rx_store) begin
                rx_wr_next   = (rx_wr_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_wr_reg + 1'b1;
                rx_fill_next = rx_fill_reg + 1'b1;
            end
            if (rx_load) begin
                rx_rd_next   = (rx_rd_reg == RX_AW'(RX_DEPTH - 1)) ? '0 : rx_rd_reg + 1'b1;
                rx_fill_next = rx_fill_reg - 1'b1;
            end

            res_next.tx_valid = tx_send;
            res_next.rd_sel   = rx_load;
            res_next.rts      = rts_next;
            res_next.rx_count = RX_COUNT_W'(rx_fill_next);
            res_next.tx_count = TX_COUNT_W'(tx_fill_next);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            phase_reg   <= PH_IDLE;
            rts_reg     <= 1'b0;
            idle_reg    <= '0;
            rx_wr_reg   <= '0;
            rx_rd_reg   <= '0;
            rx_fill_reg <= '0;
            tx_wr_reg   <= '0;
            tx_rd_reg   <= '0;
            tx_fill_reg <= '0;
            res_reg     <= '0;
        end else begin
            phase_reg   <= phase_next;
            rts_reg     <= rts_next;
            idle_reg    <= idle_next;
            rx_wr_reg   <= rx_wr_next;
            rx_rd_reg   <= rx_rd_next;
            rx_fill_reg <= rx_fill_next;
            tx_wr_reg   <= tx_wr_next;
            tx_rd_reg   <= tx_rd_next;
            tx_fill_reg <= tx_fill_next;
            res_reg     <= res_next;
        end
    end

    assign tx_req = '{we: tx_store, waddr: tx_wr_reg, wdata: item.host_byte,
                      re: tx_send, raddr: tx_rd_reg};
    assign rx_req = '{we: rx_store, waddr: rx_wr_reg, wdata: item.rx_byte,
                      re: rx_load, raddr: rx_rd_reg};
    assign res    = res_reg;

endmodule

// ----- design/serial_flow_control_buffers.sv -----
// Top level: serial front end with receive and transmit ring buffers and RTS/CTS.
//
//  channel  | ports                       | carries
//  ---------+-----------------------------+------------------------------------------
//  request  | s_tvalid s_tready s_tdata   | line status, received byte, host byte;
//           | s_tuser                     | s_tuser holds the function code
//  result   | m_tvalid m_tready m_tdata   | transmit byte, RTS, session end, counts
//  config   | cfg_wr_en cfg_index         | rx_limit, rx_extension, idle_limit
//           | cfg_wdata                   |
//
//  One request per cycle while the result is taken; each result passes the input
//  register, then the result register and buffer RAM read register.
//  Both buffers are single-port-write RAMs, one read and one write per cycle.
//  A stalled result holds the pipeline; reset is synchronous and clears all
//  pointers, fills and the session state, and needs no clearing pass.
module serial_flow_control_buffers (
    input  logic                           aclk,
    input  logic                           aresetn,
    input  logic                           s_tvalid,
    output logic                           s_tready,
    // cts, tx_empty, rx_avail, rx_byte, host_byte
    input  logic [sfcb_pkg::S_DATA_W-1:0]  s_tdata,
    // func
    input  logic [sfcb_pkg::FUNC_W-1:0]    s_tuser,
    output logic                           m_tvalid,
    input  logic                           m_tready,
    // tx_valid, tx_byte, rts, session_done, exit_status, host_rd_byte,
    // push_ok, rx_count, tx_count
    output logic [sfcb_pkg::M_DATA_W-1:0]  m_tdata,
    input  logic                           cfg_wr_en,
    input  logic [sfcb_pkg::CFG_IDX_W-1:0] cfg_index,
    input  logic [sfcb_pkg::CFG_W-1:0]     cfg_wdata
);
    import sfcb_pkg::*;

    logic        in_valid_reg, in_valid_next;
    item_t       item_reg;
    logic        m_valid_reg, m_valid_next;
    logic        fire;
    logic        s_accept;
    cfg_t        cfg;
    tx_mem_req_t tx_req;
    rx_mem_req_t rx_req;
    res_t        res;
    logic [BYTE_W-1:0] tx_q;
    logic [BYTE_W-1:0] rx_q;
    logic [BYTE_W-1:0] tx_byte;
    logic [BYTE_W-1:0] rd_byte;

    assign fire     = in_valid_reg && (!m_valid_reg || m_tready);
    assign s_tready = !in_valid_reg || fire;
    assign s_accept = s_tvalid && s_tready;

    always_comb begin
        in_valid_next = in_valid_reg;
        if (s_accept) begin
            in_valid_next = 1'b1;
        end else if (fire) begin
            in_valid_next = 1'b0;
        end
        m_valid_next = m_valid_reg;
        if (fire) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
            m_valid_reg  <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
            m_valid_reg  <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_accept) begin
            item_reg.func      <= func_t'(s_tuser);
            item_reg.cts       <= s_tdata[0];
            item_reg.tx_empty  <= s_tdata[1];
            item_reg.rx_avail  <= s_tdata[2];
            item_reg.rx_byte   <= s_tdata[3 +: BYTE_W];
            item_reg.host_byte <= s_tdata[3 + BYTE_W +: BYTE_W];
        end
    end

    sfcb_cfg u_cfg (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_wr_en (cfg_wr_en),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    sfcb_ctrl u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .fire    (fire),
        .item    (item_reg),
        .cfg     (cfg),
        .tx_req  (tx_req),
        .rx_req  (rx_req),
        .res     (res)
    );

    sfcb_ram #(.DEPTH(TX_DEPTH), .WIDTH(BYTE_W)) u_tx_ram (
        .aclk  (aclk),
        .we    (tx_req.we),
        .waddr (tx_req.waddr),
        .wdata (tx_req.wdata),
        .re    (tx_req.re),
        .raddr (tx_req.raddr),
        .rdata (tx_q)
    );

    sfcb_ram #(.DEPTH(RX_DEPTH), .WIDTH(BYTE_W)) u_rx_ram (
        .aclk  (aclk),
        .we    (rx_req.we),
        .waddr (rx_req.waddr),
        .wdata (rx_req.wdata),
        .re    (rx_req.re),
        .raddr (rx_req.raddr),
        .rdata (rx_q)
    );

    assign tx_byte  = res.tx_valid ? tx_q : '0;
    assign rd_byte  = res.rd_sel ? rx_q : '0;
    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {(M_DATA_W - M_USED_W)'(0), res.tx_count, res.rx_count,
                       res.push_ok, rd_byte, res.exit_status, res.session_done,
                       res.rts, tx_byte, res.tx_valid};

endmodule

// ----- design/sfcb_checker.sv -----
// Port-level checks for the serial flow control buffers, bound to the top level.
module sfcb_props (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [sfcb_pkg::M_DATA_W-1:0]  m_tdata
);
    import sfcb_pkg::*;

    // stalled result holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result changed while stalled");

    assert property (@(posedge aclk) !aresetn |=> !m_tvalid)
        else $error("result valid after reset");

    // no byte without tx_valid
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tdata[0] |-> m_tdata[8:1] == 8'd0)
        else $error("tx_byte set without tx_valid");

    // status only with session end, and never the unused code
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[12:11] != 2'd3) && (m_tdata[10] || m_tdata[12:11] == 2'd0))
        else $error("bad exit status");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[29:22] <= 8'(RX_DEPTH)) && (m_tdata[40:30] <= 11'(TX_DEPTH)))
        else $error("buffer count out of range");

endmodule

bind serial_flow_control_buffers sfcb_props u_sfcb_props (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
